// File: rtl/dqc_pkg.sv
package dqc_pkg;

	localparam int CURSOR_W = 4;
	localparam int COUNT_W  = 5;
	localparam int PORT_DW  = 32;

	typedef enum logic [3:0] {
		MODE_PUSH_HEAD,
		MODE_PUSH_TAIL,
		MODE_POP_HEAD,
		MODE_POP_TAIL,
		MODE_PEEK_HEAD,
		MODE_PEEK_TAIL,
		MODE_NEXT,
		MODE_PREV,
		MODE_CLEAR
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_END
	} status_t;

	// Everything of a result word except the data, which comes from the store.
	typedef struct packed {
		logic                data_valid;
		logic                cursor_valid;
		logic [CURSOR_W-1:0] cursor;
		logic [COUNT_W-1:0]  count;
		status_t             status;
	} dqc_result_t;

endpackage

// File: rtl/dqc_store.sv
module dqc_store #(
	parameter int DEPTH = 16,
	parameter int MW    = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [MW-1:0]            wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [MW-1:0]            rd_data
);

	logic [MW-1:0] mem_q [DEPTH];
	logic [MW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Every operation also reads, writes included; a read of the slot being written gets its old word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/dqc_ctrl.sv
module dqc_ctrl import dqc_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int MW    = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     commit,
	input  logic [3:0]               mode,
	input  logic [PORT_DW-1:0]       data_in,
	input  logic [CURSOR_W-1:0]      cursor_in,
	input  logic                     cursor_in_valid,
	output dqc_result_t              result,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [MW-1:0]            wr_data,
	output logic [$clog2(DEPTH)-1:0] rd_addr
);

	localparam int IW = $clog2(DEPTH);
	localparam int OW = IW + 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] slot;
	logic [15:0]   cur16;
	logic [15:0]   slot16;
	logic [15:0]   count16;
	logic [IW-1:0] cur;
	logic          cur_ok;
	logic [OW-1:0] off;
	logic [OW-1:0] cnt_w;
	logic          full;
	logic          empty;
	logic          dval;
	logic          cval;
	status_t       st;
	logic [CURSOR_W-1:0] cur_out;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] s);
		return (s == IW'(DEPTH - 1)) ? '0 : s + IW'(1);
	endfunction

	function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] s);
		return (s == '0) ? IW'(DEPTH - 1) : s - IW'(1);
	endfunction

	assign cur16   = 16'(cursor_in);
	assign cur     = cur16[IW-1:0];
	assign cur_ok  = cursor_in_valid && (cur16 < 16'(DEPTH));
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign cnt_w   = OW'(count_q);
	assign wr_addr = slot;
	assign wr_data = data_in[MW-1:0];

	// Distance of the cursor from the head, going forward around the ring.
	always_comb begin
		off = {1'b0, cur} - {1'b0, head_q};
		if (cur < head_q) begin
			off = off + OW'(DEPTH);
		end
	end

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		slot    = head_q;
		rd_addr = head_q;
		wr_en   = 1'b0;
		dval    = 1'b0;
		cval    = 1'b0;
		st      = ST_OK;
		unique case (mode_t'(mode)) inside
			MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					if (empty) begin
						slot   = head_q;
						tail_d = head_q;
					end else if (mode_t'(mode) == MODE_PUSH_HEAD) begin
						slot   = ring_prev(head_q);
						head_d = slot;
					end else begin
						slot   = ring_next(tail_q);
						tail_d = slot;
					end
					wr_en   = 1'b1;
					count_d = count_q + CW'(1);
					cval    = 1'b1;
				end
			end
			MODE_POP_HEAD, MODE_POP_TAIL: begin
				if (empty) begin
					st = ST_END;
				end else begin
					dval    = 1'b1;
					count_d = count_q - CW'(1);
					if (mode_t'(mode) == MODE_POP_HEAD) begin
						rd_addr = head_q;
						if (count_q > CW'(1)) begin
							head_d = ring_next(head_q);
						end
					end else begin
						rd_addr = tail_q;
						if (count_q > CW'(1)) begin
							tail_d = ring_prev(tail_q);
						end
					end
				end
			end
			MODE_PEEK_HEAD, MODE_PEEK_TAIL: begin
				if (empty) begin
					st = ST_END;
				end else begin
					slot    = (mode_t'(mode) == MODE_PEEK_HEAD) ? head_q : tail_q;
					rd_addr = slot;
					dval    = 1'b1;
					cval    = 1'b1;
				end
			end
			MODE_NEXT: begin
				if (cur_ok && (off + OW'(1) < cnt_w)) begin
					slot    = ring_next(cur);
					rd_addr = slot;
					dval    = 1'b1;
					cval    = 1'b1;
				end else begin
					st = ST_END;
				end
			end
			MODE_PREV: begin
				if (cur_ok && (off < cnt_w) && (off != '0)) begin
					slot    = ring_prev(cur);
					rd_addr = slot;
					dval    = 1'b1;
					cval    = 1'b1;
				end else begin
					st = ST_END;
				end
			end
			MODE_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign slot16  = 16'(slot);
	assign count16 = 16'(count_d);
	assign cur_out = cval ? slot16[CURSOR_W-1:0] : '0;
	assign result  = {dval, cval, cur_out, count16[COUNT_W-1:0], st};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (commit) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

endmodule

// File: rtl/double_ended_queue_with_cursor_top.sv
// A word accepted into the input register has its result loaded into the result
// and store read registers. Throughput: one word per cycle unless the output stalls;
// the head, tail and count registers and one store access update in one pass from
// the input register. Reset clears the pointers, the count and the valid flags at
// once; the slot store is not cleared, and only slots written since are ever shown.
module double_ended_queue_with_cursor_top import dqc_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          mode,
	input  logic [PORT_DW-1:0]  data_in,
	input  logic [CURSOR_W-1:0] cursor_in,
	input  logic                cursor_in_valid,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PORT_DW-1:0]  data_out,
	output logic                data_valid,
	output logic [CURSOR_W-1:0] cursor_out,
	output logic                cursor_out_valid,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [1:0]          status
);

	localparam int IW = $clog2(DEPTH);
	// Bits above the port width can never be set, so the store is kept narrow.
	localparam int MW = (DATA_WIDTH < PORT_DW) ? DATA_WIDTH : PORT_DW;

	logic                valid_s1;
	logic [3:0]          mode_s1;
	logic [PORT_DW-1:0]  data_s1;
	logic [CURSOR_W-1:0] cursor_s1;
	logic                cursor_valid_s1;
	logic                valid_s2;
	dqc_result_t         res_s2;
	dqc_result_t         res;
	logic                advance;
	logic                accept;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [IW-1:0]       rd_addr;
	logic [MW-1:0]       wr_data;
	logic [MW-1:0]       rd_data;
	logic [PORT_DW-1:0]  rd_ext;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1         <= mode;
			data_s1         <= data_in;
			cursor_s1       <= cursor_in;
			cursor_valid_s1 <= cursor_in_valid;
		end
	end

	dqc_ctrl #(
		.DEPTH (DEPTH),
		.MW    (MW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.commit          (advance),
		.mode            (mode_s1),
		.data_in         (data_s1),
		.cursor_in       (cursor_s1),
		.cursor_in_valid (cursor_valid_s1),
		.result          (res),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.rd_addr         (rd_addr)
	);

	// The store's read register loads together with the result register.
	dqc_store #(
		.DEPTH (DEPTH),
		.MW    (MW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en && advance),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (advance),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		rd_ext         = '0;
		rd_ext[MW-1:0] = rd_data;
	end

	assign out_valid        = valid_s2;
	assign data_out         = res_s2.data_valid ? rd_ext : '0;
	assign data_valid       = res_s2.data_valid;
	assign cursor_out       = res_s2.cursor;
	assign cursor_out_valid = res_s2.cursor_valid;
	assign entry_count      = res_s2.count;
	assign status           = res_s2.status;

endmodule

// File: tb/double_ended_queue_with_cursor_top_test.sv
module double_ended_queue_with_cursor_top_test;
	import dqc_pkg::*;

	localparam int SLOTS      = 16;
	localparam int IDLE_PCT   = 19;
	localparam int HOLD_LEN   = 80;
	localparam int QUIET_MAX  = 2000;

	typedef struct {
		logic [PORT_DW-1:0]  word;
		logic                word_ok;
		logic [CURSOR_W-1:0] handle;
		logic                handle_ok;
		logic [COUNT_W-1:0]  count;
		status_t             st;
	} dq_reply_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [3:0]          mode;
	logic [PORT_DW-1:0]  data_in;
	logic [CURSOR_W-1:0] cursor_in;
	logic                cursor_in_valid;
	logic                out_valid;
	logic                out_stall;
	logic [PORT_DW-1:0]  data_out;
	logic                data_valid;
	logic [CURSOR_W-1:0] cursor_out;
	logic                cursor_out_valid;
	logic [COUNT_W-1:0]  entry_count;
	logic [1:0]          status;

	// Shadow copy of the ring, its pointers and its count.
	logic [PORT_DW-1:0]  ring_words [SLOTS];
	logic [CURSOR_W-1:0] head_ptr;
	logic [CURSOR_W-1:0] tail_ptr;
	logic [COUNT_W-1:0]  live_count;

	dq_reply_t pending_replies[$];

	bit idle_on;
	bit stall_on;
	int hold_asked;
	int hold_done;
	int hold_left;
	int mismatches;
	int words_sent;
	int replies_seen;
	int refused_pushes;
	int end_replies;
	int quiet_cycles;

	double_ended_queue_with_cursor_top #(
		.DEPTH(SLOTS),
		.DATA_WIDTH(PORT_DW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.data_in(data_in),
		.cursor_in(cursor_in),
		.cursor_in_valid(cursor_in_valid),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.data_valid(data_valid),
		.cursor_out(cursor_out),
		.cursor_out_valid(cursor_out_valid),
		.entry_count(entry_count),
		.status(status)
	);

	always #1 clk = ~clk;

	function automatic dq_reply_t apply_deque_op(logic [3:0] op, logic [PORT_DW-1:0] word,
			logic [CURSOR_W-1:0] handle, logic handle_ok);
		dq_reply_t r;
		logic [CURSOR_W-1:0] s;
		logic [CURSOR_W-1:0] off;
		r.word = '0;
		r.word_ok = 1'b0;
		r.handle = '0;
		r.handle_ok = 1'b0;
		r.st = ST_OK;
		case (op)
			MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
				if (live_count == SLOTS) begin
					r.st = ST_FULL;
				end else begin
					if (live_count == 0) begin
						tail_ptr = head_ptr;
						s = head_ptr;
					end else if (op == MODE_PUSH_HEAD) begin
						head_ptr = head_ptr - 1'b1;
						s = head_ptr;
					end else begin
						tail_ptr = tail_ptr + 1'b1;
						s = tail_ptr;
					end
					ring_words[s] = word;
					live_count = live_count + 1'b1;
					r.handle = s;
					r.handle_ok = 1'b1;
				end
			end
			MODE_POP_HEAD, MODE_POP_TAIL: begin
				if (live_count == 0) begin
					r.st = ST_END;
				end else begin
					if (op == MODE_POP_HEAD) begin
						r.word = ring_words[head_ptr];
						if (live_count > 1) head_ptr = head_ptr + 1'b1;
					end else begin
						r.word = ring_words[tail_ptr];
						if (live_count > 1) tail_ptr = tail_ptr - 1'b1;
					end
					r.word_ok = 1'b1;
					live_count = live_count - 1'b1;
				end
			end
			MODE_PEEK_HEAD, MODE_PEEK_TAIL: begin
				if (live_count == 0) begin
					r.st = ST_END;
				end else begin
					s = (op == MODE_PEEK_HEAD) ? head_ptr : tail_ptr;
					r.word = ring_words[s];
					r.word_ok = 1'b1;
					r.handle = s;
					r.handle_ok = 1'b1;
				end
			end
			MODE_NEXT, MODE_PREV: begin
				off = handle - head_ptr;
				if (!handle_ok || live_count == 0 || off >= live_count) begin
					r.st = ST_END;
				end else if (op == MODE_NEXT && int'(off) + 1 >= int'(live_count)) begin
					r.st = ST_END;
				end else if (op == MODE_PREV && off == 0) begin
					r.st = ST_END;
				end else begin
					s = (op == MODE_NEXT) ? handle + 1'b1 : handle - 1'b1;
					r.word = ring_words[s];
					r.word_ok = 1'b1;
					r.handle = s;
					r.handle_ok = 1'b1;
				end
			end
			MODE_CLEAR: begin
				head_ptr = '0;
				tail_ptr = '0;
				live_count = '0;
			end
			default: begin
			end
		endcase
		r.count = live_count;
		return r;
	endfunction

	// Handle of the live entry k places behind the head.
	function automatic logic [CURSOR_W-1:0] live_handle(int k);
		return head_ptr + CURSOR_W'(k);
	endfunction

	task automatic send_word(logic [3:0] op, logic [PORT_DW-1:0] word,
			logic [CURSOR_W-1:0] handle, logic handle_ok);
		dq_reply_t r;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = op;
		data_in = word;
		cursor_in = handle;
		cursor_in_valid = handle_ok;
		do @(posedge clk); while (in_stall);
		r = apply_deque_op(op, word, handle, handle_ok);
		if (r.st == ST_FULL) refused_pushes++;
		if (r.st == ST_END) end_replies++;
		pending_replies.push_back(r);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic void check_field(string what, logic [PORT_DW-1:0] exp_v,
			logic [PORT_DW-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		dq_reply_t e;
		if (arst_n && out_valid && !out_stall) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				$display("%0t: result with none expected, data %h status %0d", $time,
					data_out, status);
				mismatches++;
			end else begin
				e = pending_replies.pop_front();
				check_field("data_out", e.word, data_out);
				check_field("data_valid", e.word_ok, data_valid);
				check_field("cursor_out", e.handle, cursor_out);
				check_field("cursor_out_valid", e.handle_ok, cursor_out_valid);
				check_field("entry_count", e.count, entry_count);
				check_field("status", e.st, status);
			end
		end
	end

	// Receiver side: random stalls, plus a long hold-off whenever one is asked for.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (hold_done != hold_asked) begin
			hold_done = hold_asked;
			hold_left = HOLD_LEN - 1;
			out_stall = 1'b1;
		end else begin
			out_stall = stall_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
					quiet_cycles, pending_replies.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic test_directed_cases();
		send_word(MODE_POP_HEAD, 32'h1111_1111, 4'd0, 1'b0);
		send_word(MODE_POP_TAIL, 32'h2222_2222, 4'd0, 1'b0);
		send_word(MODE_PEEK_HEAD, 32'h0, 4'd0, 1'b0);
		send_word(MODE_PEEK_TAIL, 32'h0, 4'd0, 1'b0);
		send_word(MODE_NEXT, 32'h0, 4'd0, 1'b1);
		send_word(MODE_PUSH_TAIL, 32'hFFFF_FFFF, 4'hF, 1'b1);
		send_word(MODE_PUSH_HEAD, 32'h0000_0000, 4'h0, 1'b0);
		send_word(MODE_PUSH_TAIL, 32'hA5A5_5A5A, 4'h0, 1'b0);
		send_word(MODE_PEEK_HEAD, 32'h0, 4'd0, 1'b0);
		send_word(MODE_PEEK_TAIL, 32'h0, 4'd0, 1'b0);
		// Stepping across the wrap of the ring, then off either end.
		send_word(MODE_NEXT, 32'h0, 4'd15, 1'b1);
		send_word(MODE_NEXT, 32'h0, 4'd1, 1'b1);
		send_word(MODE_PREV, 32'h0, 4'd15, 1'b1);
		send_word(MODE_PREV, 32'h0, 4'd0, 1'b1);
		send_word(MODE_NEXT, 32'h0, 4'd0, 1'b0);
		send_word(MODE_PREV, 32'h0, 4'd7, 1'b1);
		send_word(4'd9, 32'hDEAD_BEEF, 4'd3, 1'b1);
		send_word(4'd15, 32'hFFFF_FFFF, 4'd15, 1'b1);
		send_word(MODE_POP_HEAD, 32'h0, 4'd0, 1'b0);
		send_word(MODE_POP_TAIL, 32'h0, 4'd0, 1'b0);
		send_word(MODE_POP_TAIL, 32'h0, 4'd0, 1'b0);
		send_word(MODE_PUSH_HEAD, 32'h1234_5678, 4'd0, 1'b0);
		send_word(MODE_CLEAR, 32'h0, 4'd0, 1'b0);
		send_word(MODE_PEEK_HEAD, 32'h0, 4'd0, 1'b0);
	endtask

	task automatic test_full_store();
		send_word(MODE_CLEAR, $urandom, 4'($urandom), 1'($urandom));
		for (int i = 0; i < SLOTS; i++)
			send_word($urandom_range(1) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL, $urandom, 4'($urandom),
				1'($urandom));
		send_word(MODE_PUSH_HEAD, $urandom, 4'd0, 1'b0);
		send_word(MODE_PUSH_TAIL, $urandom, 4'd0, 1'b0);
		for (int i = 0; i < SLOTS; i++)
			send_word(MODE_NEXT, $urandom, live_handle(i), 1'b1);
		for (int i = 0; i < SLOTS; i++)
			send_word(MODE_PREV, $urandom, live_handle(i), 1'b1);
		for (int i = 0; i <= SLOTS; i++)
			send_word(i[0] ? MODE_POP_TAIL : MODE_POP_HEAD, $urandom, 4'($urandom), 1'($urandom));
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_asked++;
		for (int i = 0; i < 40; i++)
			send_word((i % 3 == 2) ? MODE_PEEK_TAIL : MODE_PUSH_TAIL, $urandom, 4'($urandom),
				1'b1);
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(int n);
		int phase;
		int pick;
		logic [3:0] op;
		logic [CURSOR_W-1:0] handle;
		logic handle_ok;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0) phase = $urandom_range(2);
			// A long stretch with neither side idling.
			idle_on = !(i >= 500 && i < 800);
			stall_on = idle_on;
			pick = $urandom_range(99);
			handle = 4'($urandom);
			handle_ok = 1'($urandom);
			if (pick < 2) begin
				op = 4'($urandom_range(9, 15));
			end else if (pick < 3) begin
				op = MODE_CLEAR;
			end else if (pick < (phase == 0 ? 55 : 20)) begin
				op = $urandom_range(1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
			end else if (pick < (phase == 1 ? 70 : 40)) begin
				op = $urandom_range(1) ? MODE_POP_TAIL : MODE_POP_HEAD;
			end else if (pick < 55 || (phase == 0 && pick < 65)) begin
				op = $urandom_range(1) ? MODE_PEEK_TAIL : MODE_PEEK_HEAD;
			end else begin
				op = $urandom_range(1) ? MODE_NEXT : MODE_PREV;
				handle_ok = ($urandom_range(9) != 0);
				if (live_count > 0 && $urandom_range(3) != 0)
					handle = live_handle($urandom_range(live_count - 1));
			end
			send_word(op, $urandom, handle, handle_ok);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = '0;
		data_in = '0;
		cursor_in = '0;
		cursor_in_valid = 1'b0;
		out_stall = 1'b0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		hold_asked = 0;
		hold_done = 0;
		hold_left = 0;
		mismatches = 0;
		words_sent = 0;
		replies_seen = 0;
		refused_pushes = 0;
		end_replies = 0;
		quiet_cycles = 0;
		head_ptr = '0;
		tail_ptr = '0;
		live_count = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_full_store();
		test_backpressure();
		test_random_traffic(1400);

		in_valid = 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d words and checked %0d results, all nine operations and unused modes.",
			words_sent, replies_seen);
		$display("Refused pushes on a full store: %0d; empty or end-of-list replies: %0d.",
			refused_pushes, end_replies);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: double_ended_queue_with_cursor_top.f
rtl/dqc_pkg.sv
rtl/dqc_store.sv
rtl/dqc_ctrl.sv
rtl/double_ended_queue_with_cursor_top.sv
tb/double_ended_queue_with_cursor_top_test.sv
